>>> src/salcp_pkg.sv
`default_nettype none
package salcp_pkg;

  // Default sizing of the block.
  localparam int unsigned MAX_LEN_DEF        = 4096;
  localparam int unsigned ALPHABET_BOUND_DEF = 30;

  // Symbol coding: 'a' maps to rank 1, '|' to rank 28.
  localparam int unsigned FIRST_CODE = 97;
  localparam int unsigned TOP_RANK   = 28;

  // Command codes carried by mode_i.
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

endpackage : salcp_pkg
`default_nettype wire

>>> src/suffix_array_lcp_builder_unit.sv
`default_nettype none
// Append and clear give no result, but an append to a full string returns ST_OVERFLOW; a read
// of a built string gives its result in the cycle after it is accepted, and reads may follow every cycle.
// The first in-range read after the string changes runs the build with busy_o high;
// its result then comes through S_FETCH, which rereads the stores at the held index.
// Reset (rst_ni, asynchronous, active low) empties the string; the receiver cannot stall.
module suffix_array_lcp_builder_unit #(
  parameter int unsigned MAX_LEN        = salcp_pkg::MAX_LEN_DEF,
  parameter int unsigned ALPHABET_BOUND = salcp_pkg::ALPHABET_BOUND_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  symbol_i,
  input  wire logic [11:0] index_i,
  output logic             busy_o,
  output logic             valid_o,
  output logic [11:0]      suffix_start_o,
  output logic [11:0]      lcp_prev_o,
  output logic [11:0]      position_rank_o,
  output logic [1:0]       status_o
);

  // Widths. Positions address MAX_LEN entries; lengths and ranks reach MAX_LEN itself.
  localparam int unsigned IDX_W     = $clog2(MAX_LEN);
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned TXT_W     = $clog2(ALPHABET_BOUND);
  localparam int unsigned RK_W      = (LEN_W > TXT_W) ? LEN_W : TXT_W;
  localparam int unsigned RK_DEPTH  = MAX_LEN + 1;
  localparam int unsigned RAW       = $clog2(RK_DEPTH);
  localparam int unsigned CNT_DEPTH = (MAX_LEN + 1 > ALPHABET_BOUND) ? MAX_LEN + 1
                                                                     : ALPHABET_BOUND;
  localparam int unsigned CAW       = $clog2(CNT_DEPTH);
  localparam int unsigned I_W       = CAW + 1;
  localparam int unsigned PW        = LEN_W + 1;
  localparam int unsigned SUM_W     = ((I_W > PW) ? I_W : PW) + 1;
  localparam int unsigned TOP       = (salcp_pkg::TOP_RANK < ALPHABET_BOUND - 1)
                                      ? salcp_pkg::TOP_RANK : ALPHABET_BOUND - 1;

  // Build sequencer. Each pass walks the string, one element over a few steps.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_INIT  = 12'b0000_0000_0010,
    S_CLR   = 12'b0000_0000_0100,
    S_CNT   = 12'b0000_0000_1000,
    S_PRE   = 12'b0000_0001_0000,
    S_PLACE = 12'b0000_0010_0000,
    S_REN   = 12'b0000_0100_0000,
    S_COPY  = 12'b0000_1000_0000,
    S_INV   = 12'b0001_0000_0000,
    S_KAS   = 12'b0010_0000_0000,
    S_FETCH = 12'b0100_0000_0000
  } state_e;

  localparam logic [2:0] STEP_A = 3'd0;
  localparam logic [2:0] STEP_B = 3'd1;
  localparam logic [2:0] STEP_C = 3'd2;
  localparam logic [2:0] STEP_D = 3'd3;
  localparam logic [2:0] STEP_E = 3'd4;
  localparam logic [2:0] STEP_F = 3'd5;

  state_e             state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic [I_W-1:0]     i_q, i_d;
  logic [PW-1:0]      p_q, p_d;
  logic [LEN_W-1:0]   dist_q, dist_d;
  logic [LEN_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   h_q, h_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               built_q, built_d;
  logic               sort2_q, sort2_d;
  logic [CAW-1:0]     key_q, key_d;
  logic [IDX_W-1:0]   s_q, s_d;
  logic [IDX_W-1:0]   r_q, r_d;
  logic [IDX_W-1:0]   prv_q, prv_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TXT_W-1:0]   t1_q, t1_d;
  logic [RK_W-1:0]    cur_q, cur_d;
  logic [RK_W-1:0]    prev_q, prev_d;
  logic [RK_W-1:0]    prev2_q, prev2_d;
  logic               out_v_q, out_v_d;
  logic               out_mem_q, out_mem_d;
  logic [1:0]         out_status_q, out_status_d;

  // Memory ports.
  logic               text_we;
  logic [IDX_W-1:0]   text_wa, text_ra;
  logic [TXT_W-1:0]   text_wd, text_rd;
  logic               rank_we;
  logic [RAW-1:0]     rank_wa, rank_ra;
  logic [RK_W-1:0]    rank_wd, rank_rd;
  logic               nrank_we;
  logic [IDX_W-1:0]   nrank_wa, nrank_ra;
  logic [RK_W-1:0]    nrank_wd, nrank_rd;
  logic               cnt_we;
  logic [CAW-1:0]     cnt_wa, cnt_ra;
  logic [LEN_W-1:0]   cnt_wd, cnt_rd;
  logic               sko_we;
  logic [IDX_W-1:0]   sko_wa, sko_ra, sko_wd, sko_rd;
  logic               sa_we;
  logic [IDX_W-1:0]   sa_wa, sa_ra, sa_wd, sa_rd;
  logic               inv_we;
  logic [IDX_W-1:0]   inv_wa, inv_ra, inv_wd, inv_rd;
  logic               lcp_we;
  logic [IDX_W-1:0]   lcp_wa, lcp_ra, lcp_wd, lcp_rd;

  // Shared helpers.
  logic [I_W-1:0]     n_i, lim, j_idx, base;
  logic [SUM_W-1:0]   base_p, prv_h, i_h, n_s;
  logic [RAW-1:0]     clamp_pos;
  logic [7:0]         sym_raw, sym_cap;
  logic [TXT_W-1:0]   sym_rank;
  logic               full, range_err, rank_diff;
  logic [LEN_W-1:0]   cnt_dec, h_dec, ndist;

  assign n_i   = I_W'(len_q);
  assign lim   = (n_i + I_W'(1) > I_W'(ALPHABET_BOUND)) ? n_i + I_W'(1)
                                                         : I_W'(ALPHABET_BOUND);
  assign j_idx = i_q - I_W'(1);
  assign n_s   = SUM_W'(len_q);

  // The offset-p partner of a position, clamped to the end of the string (rank 0).
  always_comb begin
    if (state_q == S_PLACE) begin
      base = j_idx;
    end else if (state_q == S_REN) begin
      base = I_W'(s_q);
    end else begin
      base = i_q;
    end
  end
  assign base_p    = SUM_W'(base) + SUM_W'(p_q);
  assign clamp_pos = (base_p < n_s) ? RAW'(base_p) : RAW'(len_q);

  assign prv_h = SUM_W'(prv_q) + SUM_W'(h_q);
  assign i_h   = SUM_W'(i_q) + SUM_W'(h_q);
  assign h_dec = (h_q == '0) ? '0 : h_q - LEN_W'(1);

  assign cnt_dec = cnt_rd - LEN_W'(1);

  // Symbol to rank: codes below 'a' become rank 1, everything is capped at TOP.
  assign sym_raw  = ({1'b0, symbol_i} < 8'(salcp_pkg::FIRST_CODE)) ? 8'd1
                    : {1'b0, symbol_i} - 8'(salcp_pkg::FIRST_CODE - 1);
  assign sym_cap  = (sym_raw > 8'(TOP)) ? 8'(TOP) : sym_raw;
  assign sym_rank = TXT_W'(sym_cap);

  assign full      = (32'(len_q) >= MAX_LEN);
  assign range_err = (32'(index_i) >= 32'(len_q));

  // A new rank starts wherever the (rank, rank at offset p) pair changes.
  assign rank_diff = (cur_q != prev_q) || (rank_rd != prev2_q);
  assign ndist     = (i_q == '0) ? LEN_W'(1)
                   : (rank_diff ? dist_q + LEN_W'(1) : dist_q);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    i_d          = i_q;
    p_d          = p_q;
    dist_d       = dist_q;
    acc_d        = acc_q;
    h_d          = h_q;
    len_d        = len_q;
    built_d      = built_q;
    sort2_d      = sort2_q;
    key_d        = key_q;
    s_d          = s_q;
    r_d          = r_q;
    prv_d        = prv_q;
    idx_d        = idx_q;
    t1_d         = t1_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev2_d      = prev2_q;
    out_v_d      = 1'b0;
    out_mem_d    = 1'b0;
    out_status_d = salcp_pkg::ST_OK;

    text_we  = 1'b0; text_wa  = '0; text_wd  = '0; text_ra  = '0;
    rank_we  = 1'b0; rank_wa  = '0; rank_wd  = '0; rank_ra  = '0;
    nrank_we = 1'b0; nrank_wa = '0; nrank_wd = '0; nrank_ra = '0;
    cnt_we   = 1'b0; cnt_wa   = '0; cnt_wd   = '0; cnt_ra   = '0;
    sko_we   = 1'b0; sko_wa   = '0; sko_wd   = '0; sko_ra   = '0;
    sa_we    = 1'b0; sa_wa    = '0; sa_wd    = '0; sa_ra    = '0;
    inv_we   = 1'b0; inv_wa   = '0; inv_wd   = '0; inv_ra   = '0;
    lcp_we   = 1'b0; lcp_wa   = '0; lcp_wd   = '0; lcp_ra   = '0;

    case (state_q)
      S_IDLE: begin
        // Result stores are read at the requested index every idle cycle.
        sa_ra  = IDX_W'(index_i);
        lcp_ra = IDX_W'(index_i);
        inv_ra = IDX_W'(index_i);
        if (start_i) begin
          case (mode_i)
            salcp_pkg::MODE_APPEND: begin
              if (full) begin
                out_v_d      = 1'b1;
                out_status_d = salcp_pkg::ST_OVERFLOW;
              end else begin
                text_we = 1'b1;
                text_wa = IDX_W'(len_q);
                text_wd = sym_rank;
                len_d   = len_q + LEN_W'(1);
                built_d = 1'b0;
              end
            end
            salcp_pkg::MODE_READ: begin
              if (range_err) begin
                out_v_d      = 1'b1;
                out_status_d = salcp_pkg::ST_RANGE;
              end else if (built_q) begin
                out_v_d   = 1'b1;
                out_mem_d = 1'b1;
              end else begin
                idx_d   = IDX_W'(index_i);
                state_d = S_INIT;
                step_d  = STEP_A;
                i_d     = '0;
                p_d     = PW'(1);
                dist_d  = LEN_W'(1);
              end
            end
            salcp_pkg::MODE_CLEAR: begin
              len_d   = '0;
              built_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INIT: begin
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              rank_we = 1'b1;
              rank_wa = RAW'(len_q);
              rank_wd = '0;
              state_d = S_CLR;
              sort2_d = 1'b0;
              i_d     = '0;
            end else begin
              text_ra = IDX_W'(i_q);
              step_d  = STEP_B;
            end
          end
          default: begin
            rank_we = 1'b1;
            rank_wa = RAW'(i_q);
            rank_wd = RK_W'(text_rd);
            i_d     = i_q + I_W'(1);
            step_d  = STEP_A;
          end
        endcase
      end

      S_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = CAW'(i_q);
        cnt_wd = '0;
        if (i_q == lim - I_W'(1)) begin
          i_d     = '0;
          state_d = S_CNT;
          step_d  = STEP_A;
        end else begin
          i_d = i_q + I_W'(1);
        end
      end

      S_CNT: begin
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              i_d     = '0;
              acc_d   = '0;
              state_d = S_PRE;
            end else begin
              rank_ra = sort2_q ? RAW'(i_q) : clamp_pos;
              step_d  = STEP_B;
            end
          end
          STEP_B: begin
            key_d  = CAW'(rank_rd);
            cnt_ra = CAW'(rank_rd);
            step_d = STEP_C;
          end
          default: begin
            cnt_we = 1'b1;
            cnt_wa = key_q;
            cnt_wd = cnt_rd + LEN_W'(1);
            i_d    = i_q + I_W'(1);
            step_d = STEP_A;
          end
        endcase
      end

      S_PRE: begin
        case (step_q)
          STEP_A: begin
            if (i_q == lim) begin
              i_d     = n_i;
              state_d = S_PLACE;
            end else begin
              cnt_ra = CAW'(i_q);
              step_d = STEP_B;
            end
          end
          default: begin
            cnt_we = 1'b1;
            cnt_wa = CAW'(i_q);
            cnt_wd = acc_q + cnt_rd;
            acc_d  = acc_q + cnt_rd;
            i_d    = i_q + I_W'(1);
            step_d = STEP_A;
          end
        endcase
      end

      S_PLACE: begin
        // Walks positions from the top down so that both sorts stay stable.
        case (step_q)
          STEP_A: begin
            if (i_q == '0) begin
              i_d = '0;
              if (!sort2_q) begin
                sort2_d = 1'b1;
                state_d = S_CLR;
              end else if (dist_q == len_q) begin
                state_d = S_INV;
              end else begin
                state_d = S_REN;
              end
            end else if (sort2_q) begin
              sko_ra = IDX_W'(j_idx);
              step_d = STEP_B;
            end else begin
              s_d     = IDX_W'(j_idx);
              rank_ra = clamp_pos;
              step_d  = STEP_C;
            end
          end
          STEP_B: begin
            s_d     = sko_rd;
            rank_ra = RAW'(sko_rd);
            step_d  = STEP_C;
          end
          STEP_C: begin
            key_d  = CAW'(rank_rd);
            cnt_ra = CAW'(rank_rd);
            step_d = STEP_D;
          end
          default: begin
            cnt_we = 1'b1;
            cnt_wa = key_q;
            cnt_wd = cnt_dec;
            if (sort2_q) begin
              sa_we = 1'b1;
              sa_wa = IDX_W'(cnt_dec);
              sa_wd = s_q;
            end else begin
              sko_we = 1'b1;
              sko_wa = IDX_W'(cnt_dec);
              sko_wd = s_q;
            end
            i_d    = j_idx;
            step_d = STEP_A;
          end
        endcase
      end

      S_REN: begin
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              i_d     = '0;
              state_d = S_COPY;
            end else begin
              sa_ra  = IDX_W'(i_q);
              step_d = STEP_B;
            end
          end
          STEP_B: begin
            s_d     = sa_rd;
            rank_ra = RAW'(sa_rd);
            step_d  = STEP_C;
          end
          STEP_C: begin
            cur_d   = rank_rd;
            rank_ra = clamp_pos;
            step_d  = STEP_D;
          end
          default: begin
            nrank_we = 1'b1;
            nrank_wa = s_q;
            nrank_wd = RK_W'(ndist);
            dist_d   = ndist;
            prev_d   = cur_q;
            prev2_d  = rank_rd;
            i_d      = i_q + I_W'(1);
            step_d   = STEP_A;
          end
        endcase
      end

      S_COPY: begin
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              p_d     = p_q << 1;
              i_d     = '0;
              sort2_d = 1'b0;
              state_d = S_CLR;
            end else begin
              nrank_ra = IDX_W'(i_q);
              step_d   = STEP_B;
            end
          end
          default: begin
            rank_we = 1'b1;
            rank_wa = RAW'(i_q);
            rank_wd = nrank_rd;
            i_d     = i_q + I_W'(1);
            step_d  = STEP_A;
          end
        endcase
      end

      S_INV: begin
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              i_d     = '0;
              h_d     = '0;
              state_d = S_KAS;
            end else begin
              sa_ra  = IDX_W'(i_q);
              step_d = STEP_B;
            end
          end
          default: begin
            inv_we = 1'b1;
            inv_wa = sa_rd;
            inv_wd = IDX_W'(i_q);
            i_d    = i_q + I_W'(1);
            step_d = STEP_A;
          end
        endcase
      end

      S_KAS: begin
        // Kasai: extend the carried match length h one symbol pair at a time.
        case (step_q)
          STEP_A: begin
            if (i_q == n_i) begin
              built_d = 1'b1;
              state_d = S_FETCH;
            end else begin
              inv_ra = IDX_W'(i_q);
              step_d = STEP_B;
            end
          end
          STEP_B: begin
            r_d = inv_rd;
            if (inv_rd == '0) begin
              lcp_we = 1'b1;
              lcp_wa = '0;
              lcp_wd = '0;
              h_d    = h_dec;
              i_d    = i_q + I_W'(1);
              step_d = STEP_A;
            end else begin
              sa_ra  = inv_rd - IDX_W'(1);
              step_d = STEP_C;
            end
          end
          STEP_C: begin
            prv_d  = sa_rd;
            step_d = STEP_D;
          end
          STEP_D: begin
            if ((prv_h < n_s) && (i_h < n_s)) begin
              text_ra = IDX_W'(prv_h);
              step_d  = STEP_E;
            end else begin
              lcp_we = 1'b1;
              lcp_wa = r_q;
              lcp_wd = IDX_W'(h_q);
              h_d    = h_dec;
              i_d    = i_q + I_W'(1);
              step_d = STEP_A;
            end
          end
          STEP_E: begin
            t1_d    = text_rd;
            text_ra = IDX_W'(i_h);
            step_d  = STEP_F;
          end
          default: begin
            if (text_rd == t1_q) begin
              h_d    = h_q + LEN_W'(1);
              step_d = STEP_D;
            end else begin
              lcp_we = 1'b1;
              lcp_wa = r_q;
              lcp_wd = IDX_W'(h_q);
              h_d    = h_dec;
              i_d    = i_q + I_W'(1);
              step_d = STEP_A;
            end
          end
        endcase
      end

      S_FETCH: begin
        // The held read is served from the freshly built stores.
        sa_ra     = idx_q;
        lcp_ra    = idx_q;
        inv_ra    = idx_q;
        out_v_d   = 1'b1;
        out_mem_d = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      built_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      built_q <= built_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    i_q          <= i_d;
    p_q          <= p_d;
    dist_q       <= dist_d;
    acc_q        <= acc_d;
    h_q          <= h_d;
    sort2_q      <= sort2_d;
    key_q        <= key_d;
    s_q          <= s_d;
    r_q          <= r_d;
    prv_q        <= prv_d;
    idx_q        <= idx_d;
    t1_q         <= t1_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev2_q      <= prev2_d;
    out_mem_q    <= out_mem_d;
    out_status_q <= out_status_d;
  end

  salcp_ram #(.WIDTH(TXT_W), .DEPTH(MAX_LEN)) u_text (
    .clk_i, .we_i(text_we), .waddr_i(text_wa), .wdata_i(text_wd),
    .raddr_i(text_ra), .rdata_o(text_rd)
  );
  salcp_ram #(.WIDTH(RK_W), .DEPTH(RK_DEPTH)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_wa), .wdata_i(rank_wd),
    .raddr_i(rank_ra), .rdata_o(rank_rd)
  );
  salcp_ram #(.WIDTH(RK_W), .DEPTH(MAX_LEN)) u_nrank (
    .clk_i, .we_i(nrank_we), .waddr_i(nrank_wa), .wdata_i(nrank_wd),
    .raddr_i(nrank_ra), .rdata_o(nrank_rd)
  );
  salcp_ram #(.WIDTH(LEN_W), .DEPTH(CNT_DEPTH)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_wa), .wdata_i(cnt_wd),
    .raddr_i(cnt_ra), .rdata_o(cnt_rd)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_sko (
    .clk_i, .we_i(sko_we), .waddr_i(sko_wa), .wdata_i(sko_wd),
    .raddr_i(sko_ra), .rdata_o(sko_rd)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_sa (
    .clk_i, .we_i(sa_we), .waddr_i(sa_wa), .wdata_i(sa_wd),
    .raddr_i(sa_ra), .rdata_o(sa_rd)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_inv (
    .clk_i, .we_i(inv_we), .waddr_i(inv_wa), .wdata_i(inv_wd),
    .raddr_i(inv_ra), .rdata_o(inv_rd)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_lcp (
    .clk_i, .we_i(lcp_we), .waddr_i(lcp_wa), .wdata_i(lcp_wd),
    .raddr_i(lcp_ra), .rdata_o(lcp_rd)
  );

  // Error results carry zeros; good reads take the registered store outputs.
  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = out_v_q;
  assign suffix_start_o  = out_mem_q ? 12'(sa_rd)  : 12'd0;
  assign lcp_prev_o      = out_mem_q ? 12'(lcp_rd) : 12'd0;
  assign position_rank_o = out_mem_q ? 12'(inv_rd) : 12'd0;
  assign status_o        = out_status_q;

`ifndef NO_ASSERTIONS
  a_fetch_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |=> out_v_q && out_mem_q)
    else $error("build end did not deliver the held read");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $past(state_q == S_IDLE || state_q == S_FETCH))
    else $error("result strobe raised during a build pass");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_status_q != salcp_pkg::ST_OK |-> !out_mem_q)
    else $error("error result taken from the stores");

  a_len_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |=> $stable(len_q))
    else $error("string length changed during a build");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= MAX_LEN)
    else $error("string length beyond capacity");
`endif

endmodule : suffix_array_lcp_builder_unit
`default_nettype wire

>>> src/salcp_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module salcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : salcp_ram
`default_nettype wire

>>> verif/salcp_checker.sv
module salcp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  symbol_i,
  input  wire logic [11:0] index_i,
  input  wire logic        busy_i,
  input  wire logic        valid_i,
  input  wire logic [11:0] suffix_start_i,
  input  wire logic [11:0] lcp_prev_i,
  input  wire logic [11:0] position_rank_i,
  input  wire logic [1:0]  status_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] start;
    logic [11:0] lcp;
    logic [11:0] rnk;
    logic [1:0]  st;
  } lookup_t;

  lookup_t     lookups_due[$];
  int unsigned text_syms[salcp_pkg::MAX_LEN_DEF];
  int unsigned text_len;
  bit          sa_ready;
  int unsigned sa_tab[salcp_pkg::MAX_LEN_DEF];
  int unsigned inv_tab[salcp_pkg::MAX_LEN_DEF];
  int unsigned lcp_tab[salcp_pkg::MAX_LEN_DEF];
  int unsigned cls[salcp_pkg::MAX_LEN_DEF + 1];
  int unsigned cls_next[salcp_pkg::MAX_LEN_DEF];
  int unsigned hist[salcp_pkg::MAX_LEN_DEF + salcp_pkg::ALPHABET_BOUND_DEF + 1];
  int unsigned by_second[salcp_pkg::MAX_LEN_DEF];

  function automatic int unsigned clip(int unsigned x, int unsigned n);
    return (x < n) ? x : n;
  endfunction

  // Prefix doubling with two stable counting sorts per round, then Kasai.
  function automatic void build_suffix_array();
    int unsigned n, lim, step, classes, k, a, b, r, h;
    int i;
    n = text_len;
    lim = (n + 1 > salcp_pkg::ALPHABET_BOUND_DEF) ? n + 1 : salcp_pkg::ALPHABET_BOUND_DEF;
    step = 1;
    classes = 1;
    for (i = 0; i < n; i++) begin
      sa_tab[i] = i;
      cls[i] = text_syms[i];
    end
    cls[n] = 0;
    forever begin
      for (i = 0; i < lim; i++) hist[i] = 0;
      for (i = 0; i < n; i++) hist[cls[clip(i + step, n)]]++;
      for (i = 1; i < lim; i++) hist[i] += hist[i - 1];
      for (i = n - 1; i >= 0; i--) begin
        k = cls[clip(i + step, n)];
        hist[k]--;
        by_second[hist[k]] = i;
      end
      for (i = 0; i < lim; i++) hist[i] = 0;
      for (i = 0; i < n; i++) hist[cls[i]]++;
      for (i = 1; i < lim; i++) hist[i] += hist[i - 1];
      for (i = n - 1; i >= 0; i--) begin
        k = cls[by_second[i]];
        hist[k]--;
        sa_tab[hist[k]] = by_second[i];
      end
      if (classes == n) break;
      classes = 1;
      cls_next[sa_tab[0]] = 1;
      for (i = 1; i < n; i++) begin
        a = sa_tab[i - 1];
        b = sa_tab[i];
        if (cls[a] != cls[b] || cls[clip(a + step, n)] != cls[clip(b + step, n)])
          classes++;
        cls_next[b] = classes;
      end
      for (i = 0; i < n; i++) cls[i] = cls_next[i];
      step *= 2;
    end
    for (i = 0; i < n; i++) inv_tab[sa_tab[i]] = i;
    h = 0;
    for (i = 0; i < n; i++) begin
      r = inv_tab[i];
      if (r != 0) begin
        a = sa_tab[r - 1];
        while (a + h < n && i + h < n && text_syms[a + h] == text_syms[i + h]) h++;
        lcp_tab[r] = h;
      end else begin
        lcp_tab[0] = 0;
      end
      if (h > 0) h--;
    end
    sa_ready = 1'b1;
  endfunction

  // Returns 1 when the item produces a result, with the expected fields in res.
  function automatic bit predict_item(logic [1:0] mode, logic [6:0] sym, logic [11:0] idx,
                                      output lookup_t res);
    int unsigned r;
    res = '0;
    case (mode)
      salcp_pkg::MODE_APPEND: begin
        if (text_len >= salcp_pkg::MAX_LEN_DEF) begin
          res.st = salcp_pkg::ST_OVERFLOW;
          return 1'b1;
        end
        r = (sym < salcp_pkg::FIRST_CODE) ? 1 : sym - (salcp_pkg::FIRST_CODE - 1);
        if (r > salcp_pkg::TOP_RANK) r = salcp_pkg::TOP_RANK;
        text_syms[text_len] = r;
        text_len++;
        sa_ready = 1'b0;
        return 1'b0;
      end
      salcp_pkg::MODE_READ: begin
        if (idx >= text_len) begin
          res.st = salcp_pkg::ST_RANGE;
          return 1'b1;
        end
        if (!sa_ready) build_suffix_array();
        res.start = 12'(sa_tab[idx]);
        res.lcp   = 12'(lcp_tab[idx]);
        res.rnk   = 12'(inv_tab[idx]);
        res.st    = salcp_pkg::ST_OK;
        return 1'b1;
      end
      salcp_pkg::MODE_CLEAR: begin
        text_len = 0;
        sa_ready = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want, got;
    if (!rst_ni) begin
      lookups_due.delete();
      text_len  = 0;
      sa_ready  = 1'b0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Retire the result first so a same-edge acceptance cannot be matched to it.
      if (valid_i) begin
        got = '{suffix_start_i, lcp_prev_i, position_rank_i, status_i};
        if (lookups_due.size() == 0) begin
          if (errors_o < 10) $display("%0t: unexpected result %p", $realtime, got);
          errors_o <= errors_o + 1;
        end else begin
          want = lookups_due.pop_front();
          if (want !== got) begin
            if (errors_o < 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i && predict_item(mode_i, symbol_i, index_i, want))
        lookups_due = {lookups_due, want};
      pending_o <= lookups_due.size();
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import salcp_pkg::*;

  // Mode 3 is unused by the block and must simply be ignored.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1800;
  localparam int CALM_TAIL   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  mode_i = MODE_APPEND;
  logic [6:0]  symbol_i = '0;
  logic [11:0] index_i = '0;
  logic        busy_o, valid_o;
  logic [11:0] suffix_start_o, lcp_prev_o, position_rank_o;
  logic [1:0]  status_o;
  int          errors, pending;
  int          items_sent = 0;
  int          cur_len = 0;

  suffix_array_lcp_builder_unit DUT (
    .clk_i, .rst_ni, .start_i, .mode_i, .symbol_i, .index_i, .busy_o, .valid_o,
    .suffix_start_o, .lcp_prev_o, .position_rank_o, .status_o
  );

  salcp_checker u_checker (
    .clk_i, .rst_ni, .start_i, .mode_i, .symbol_i, .index_i,
    .busy_i(busy_o), .valid_i(valid_o), .suffix_start_i(suffix_start_o),
    .lcp_prev_i(lcp_prev_o), .position_rank_i(position_rank_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Presents one item and returns at the edge where it is accepted. Since busy_o only
  // moves at rising edges, its value at the falling edge is what the next edge sees.
  task automatic issue(logic [1:0] mode, logic [6:0] sym, logic [11:0] idx);
    start_i  <= 1'b1;
    mode_i   <= mode;
    symbol_i <= sym;
    index_i  <= idx;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    items_sent++;
    if (mode == MODE_APPEND && cur_len < MAX_LEN_DEF) cur_len++;
    if (mode == MODE_CLEAR) cur_len = 0;
  endtask

  // Sender gaps come in bursts, and stop entirely near the end of the run.
  task automatic maybe_gap();
    if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Biased symbol choice: small alphabets give long repeats and deep LCPs.
  function automatic logic [6:0] pick_symbol(int unsigned flavor);
    case (flavor)
      0: return 7'(FIRST_CODE + $urandom_range(1));
      1: return 7'(FIRST_CODE + $urandom_range(3));
      2: return 7'($urandom_range(127));
      default: return 7'($urandom_range(FIRST_CODE + TOP_RANK - 1, FIRST_CODE));
    endcase
  endfunction

  initial begin
    int unsigned len, flavor, reads;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty reads, symbol extremes, clamping, every mode.
    issue(MODE_READ, 7'd0, 12'd0);
    issue(MODE_READ, 7'd0, 12'hFFF);
    issue(MODE_UNUSED, 7'h7F, 12'hFFF);
    issue(MODE_APPEND, 7'd97, 12'd0);
    issue(MODE_READ, 7'd0, 12'd0);
    issue(MODE_APPEND, 7'd124, 12'd0);
    issue(MODE_APPEND, 7'd0, 12'd0);
    issue(MODE_APPEND, 7'h7F, 12'd0);
    issue(MODE_APPEND, 7'd97, 12'd0);
    issue(MODE_APPEND, 7'd97, 12'd0);
    for (int i = 0; i < 6; i++) issue(MODE_READ, 7'd0, 12'(i));
    issue(MODE_READ, 7'd0, 12'd6);
    issue(MODE_UNUSED, 7'd0, 12'd0);
    issue(MODE_READ, 7'd0, 12'd2);
    issue(MODE_CLEAR, 7'd0, 12'd0);
    issue(MODE_READ, 7'd0, 12'd0);
    drain();

    // Random part: mostly clear, load, read sequences with stray noise mixed in.
    while (items_sent < ITEM_TARGET) begin
      issue(MODE_CLEAR, pick_symbol(2), 12'($urandom_range(4095)));
      maybe_gap();
      len = ($urandom_range(30) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
      flavor = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        issue(MODE_APPEND, pick_symbol(flavor), 12'($urandom_range(4095)));
        maybe_gap();
      end
      reads = $urandom_range(12, 2);
      for (int i = 0; i < reads; i++) begin
        case ($urandom_range(9))
          0: issue(MODE_READ, pick_symbol(2), 12'($urandom_range(4095)));
          1: issue(MODE_UNUSED, pick_symbol(2), 12'($urandom_range(4095)));
          2: issue(MODE_APPEND, pick_symbol(flavor), 12'($urandom_range(4095)));
          3: issue(MODE_READ, pick_symbol(2), 12'(cur_len));
          default: issue(MODE_READ, pick_symbol(2), 12'($urandom_range(cur_len - 1)));
        endcase
        maybe_gap();
      end
      if ($urandom_range(7) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
